// ===== rtl/tsb_pkg.sv =====
package tsb_pkg;

    localparam int ACT_W     = 3;
    localparam int COORD_W   = 24;
    localparam int FRAC_W    = 16;
    localparam int CH_W      = 8;
    localparam int WORD_W    = 32;
    localparam int SIZE_W    = 9;
    localparam int CFG_IDX_W = 4;
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);

    localparam logic [ACT_W-1:0] ACT_PAL_WR  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_IDX_WR  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ARGB_WR = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POINT   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_BILIN   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 4'd1;

    // work kind of an item once it reaches the texel RAM sequencer
    typedef enum logic [1:0] {
        K_NONE,
        K_WRITE,
        K_POINT,
        K_BILIN
    } t_kind;

    // four gathered texels, slot order (x0,y0) (x1,y0) (x0,y1) (x1,y1)
    typedef struct packed {
        logic [3:0][WORD_W-1:0] texel;
        logic [CH_W-1:0]        wa;
        logic [CH_W-1:0]        wb;
    } t_quad;

endpackage

// ===== rtl/tsb_sample_if.sv =====
interface tsb_sample_if;
    import tsb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACT_W-1:0]           action;
    logic [7:0]                 texel_x;
    logic [7:0]                 texel_y;
    logic [7:0]                 palette_index;
    logic [WORD_W-1:0]          data_word;
    logic signed [COORD_W-1:0]  u_coord;
    logic signed [COORD_W-1:0]  v_coord;

    modport source (
        output valid, action, texel_x, texel_y, palette_index, data_word, u_coord, v_coord,
        input  ready
    );
    modport sink (
        input  valid, action, texel_x, texel_y, palette_index, data_word, u_coord, v_coord,
        output ready
    );
endinterface

// ===== rtl/tsb_result_if.sv =====
interface tsb_result_if;
    import tsb_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] chan_x;
    logic [CH_W-1:0] chan_y;
    logic [CH_W-1:0] chan_z;
    logic [CH_W-1:0] chan_w;

    modport source (output valid, chan_x, chan_y, chan_z, chan_w, input ready);
    modport sink   (input valid, chan_x, chan_y, chan_z, chan_w, output ready);
endinterface

// ===== rtl/tsb_cfg_if.sv =====
interface tsb_cfg_if;
    import tsb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tsb_blend.sv =====
module tsb_blend (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tsb_pkg::t_quad i_quad,
    output logic          o_ready,
    tsb_result_if.source  o_res
);
    import tsb_pkg::*;

    localparam int ROW_W = 2 * CH_W;       // one row blend, max 255*256
    localparam int SUM_W = 2 * CH_W + 9;   // row product with a 9-bit weight

    logic                       r_b1_v;
    logic [3:0][ROW_W-1:0]      r_top;
    logic [3:0][ROW_W-1:0]      r_bot;
    logic [CH_W-1:0]            r_wb;
    logic                       r_o_v;
    logic [3:0][CH_W-1:0]       r_chan;

    logic [3:0][ROW_W-1:0]      n_top;
    logic [3:0][ROW_W-1:0]      n_bot;
    logic [3:0][CH_W-1:0]       n_chan;
    logic                       out_ld;
    logic                       b1_go;

    assign out_ld  = !r_o_v || o_res.ready;
    assign b1_go   = r_b1_v && out_ld;
    assign o_ready = !r_b1_v || b1_go;

    // horizontal blend of both rows
    always_comb begin
        logic [ROW_W:0] wa_n;
        logic [ROW_W:0] wa;
        logic [ROW_W:0] t;
        logic [ROW_W:0] b;
        wa_n = (ROW_W+1)'(9'd256 - {1'b0, i_quad.wa});
        wa   = (ROW_W+1)'(i_quad.wa);
        for (int k = 0; k < 4; k++) begin
            t = (ROW_W+1)'(i_quad.texel[0][k*CH_W +: CH_W]) * wa_n
              + (ROW_W+1)'(i_quad.texel[1][k*CH_W +: CH_W]) * wa;
            b = (ROW_W+1)'(i_quad.texel[2][k*CH_W +: CH_W]) * wa_n
              + (ROW_W+1)'(i_quad.texel[3][k*CH_W +: CH_W]) * wa;
            n_top[k] = t[ROW_W-1:0];
            n_bot[k] = b[ROW_W-1:0];
        end
    end

    // vertical blend and round to 8 bits
    always_comb begin
        logic [SUM_W-1:0] wb_n;
        logic [SUM_W-1:0] wb;
        logic [SUM_W-1:0] s;
        wb_n = SUM_W'(9'd256 - {1'b0, r_wb});
        wb   = SUM_W'(r_wb);
        for (int k = 0; k < 4; k++) begin
            s = SUM_W'(r_top[k]) * wb_n + SUM_W'(r_bot[k]) * wb + SUM_W'(17'h08000);
            n_chan[k] = s[FRAC_W +: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_b1_v <= i_valid;
            end
            if (out_ld) begin
                r_o_v <= r_b1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_top <= n_top;
            r_bot <= n_bot;
            r_wb  <= i_quad.wb;
        end
        if (b1_go) begin
            r_chan <= n_chan;
        end
    end

    assign o_res.valid  = r_o_v;
    assign o_res.chan_x = r_chan[0];
    assign o_res.chan_y = r_chan[1];
    assign o_res.chan_z = r_chan[2];
    assign o_res.chan_w = r_chan[3];

endmodule

// ===== rtl/texture_sampler_bilinear_core.sv =====
// Texture sampler with texel RAM and a 256-entry palette.
// Channels: i_smp carries write and sample transactions (valid/ready), o_res
// returns one result transaction per point or bilinear sample, i_cfg writes
// tex_width (index 0) and tex_height (index 1); i_cfg is always ready. The user must
// see that i_cfg is written only while the block is idle; the block does not enforce it.
// Texel writes and point samples each use the texel RAM once and bilinear samples
// read it four times, as its single port serves one write or one read per cycle;
// palette writes pass through stage 2 without using it.
// A sample is registered in stage 1, the stage 2 sequencer, the RAM read register,
// the gather register and the blend row and output registers before o_res.valid.
// A texel write passes stage 1 and is written to the RAM from stage 2; later samples
// always see it. An indexed write reads the palette when accepted.
// Reset clears all pipeline valids and sets both sizes to 256; the RAM and
// palette contents are not cleared and must be written before they are read.
// When the receiver stalls, the output register and the stages behind it
// fill up and i_smp.ready drops only once no stage can take another item.
module texture_sampler_bilinear_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsb_sample_if.sink    i_smp,
    tsb_result_if.source  o_res,
    tsb_cfg_if.sink       i_cfg
);
    import tsb_pkg::*;

    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int TEX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW        = $clog2(TEX_DEPTH);
    localparam int PUW       = XW + FRAC_W;
    localparam int PVW       = YW + FRAC_W;

    // configuration
    logic [SIZE_W-1:0]    r_tex_width;
    logic [SIZE_W-1:0]    r_tex_height;
    logic [XW-1:0]        sx;
    logic [YW-1:0]        sy;

    // memories
    logic [WORD_W-1:0]    r_pal_mem [PAL_DEPTH];
    logic [WORD_W-1:0]    r_pal_q;
    logic [WORD_W-1:0]    r_tex_mem [TEX_DEPTH];
    logic [WORD_W-1:0]    r_tex_q;

    // stage 1: captured item
    logic                 r1_v;
    logic [ACT_W-1:0]     r1_action;
    logic [7:0]           r1_x;
    logic [7:0]           r1_y;
    logic [WORD_W-1:0]    r1_word;
    logic [FRAC_W-1:0]    r1_fu;
    logic [FRAC_W-1:0]    r1_fv;

    // stage 2: texel RAM sequencer
    logic                 r2_v;
    t_kind                r2_kind;
    logic [WORD_W-1:0]    r2_word;
    logic [AW-1:0]        r2_waddr;
    logic [PUW-1:0]       r2_pu;
    logic [PVW-1:0]       r2_pv;
    logic [1:0]           r_cnt;

    // read return and gather
    logic                 r_r_v;
    logic [1:0]           r_r_slot;
    logic                 r_r_last;
    logic                 r_r_all;
    logic [CH_W-1:0]      r_r_a;
    logic [CH_W-1:0]      r_r_b;
    logic                 r_g_v;
    t_quad                r_g_quad;

    logic                 accept;
    logic                 s1_go;
    logic                 s2_ld;
    logic                 s2_step;
    logic                 s2_last;
    logic                 s2_go;
    logic                 r_go;
    logic                 r_free;
    logic                 g_go;
    logic                 blend_ready;
    logic                 tex_we;
    logic                 tex_re;
    logic [AW-1:0]        tex_addr;

    t_kind                n2_kind;
    logic [WORD_W-1:0]    n2_word;
    logic [AW-1:0]        n2_waddr;

    logic [XW-1:0]        x0;
    logic [XW-1:0]        x1;
    logic [YW-1:0]        y0;
    logic [YW-1:0]        y1;
    logic [AW-1:0]        rd_addr;

    function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
        return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= SIZE_W'(256);
            r_tex_height <= SIZE_W'(256);
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_TEX_WIDTH) begin
                r_tex_width <= i_cfg.data;
            end else if (i_cfg.index == REG_TEX_HEIGHT) begin
                r_tex_height <= i_cfg.data;
            end
        end
    end

    // last texel index; zero acts as one, oversize acts as the maximum
    always_comb begin
        if (r_tex_width == '0) begin
            sx = '0;
        end else if (int'(r_tex_width) > MAX_WIDTH) begin
            sx = XW'(MAX_WIDTH - 1);
        end else begin
            sx = XW'(r_tex_width - 1'b1);
        end
        if (r_tex_height == '0) begin
            sy = '0;
        end else if (int'(r_tex_height) > MAX_HEIGHT) begin
            sy = YW'(MAX_HEIGHT - 1);
        end else begin
            sy = YW'(r_tex_height - 1'b1);
        end
    end

    // ---------------- handshake chain ----------------
    assign g_go   = r_g_v && blend_ready;
    assign r_go   = r_r_v && (!r_g_v || g_go);
    assign r_free = !r_r_v || r_go;
    assign s2_go  = r2_v && s2_step && s2_last;
    assign s2_ld  = !r2_v || s2_go;
    assign s1_go  = r1_v && s2_ld;

    assign i_smp.ready = !r1_v || s1_go;
    assign accept      = i_smp.valid && i_smp.ready;

    // ---------------- palette ----------------
    always_ff @(posedge i_clk) begin
        if (accept && i_smp.action == ACT_PAL_WR) begin
            r_pal_mem[i_smp.palette_index[PAL_AW-1:0]] <= i_smp.data_word;
        end
        if (accept) begin
            r_pal_q <= r_pal_mem[i_smp.palette_index[PAL_AW-1:0]];
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_smp.ready) begin
            r1_v <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_action <= i_smp.action;
            r1_x      <= i_smp.texel_x;
            r1_y      <= i_smp.texel_y;
            r1_word   <= i_smp.data_word;
            // negative coordinate samples at zero
            r1_fu     <= i_smp.u_coord[COORD_W-1] ? '0 : i_smp.u_coord[FRAC_W-1:0];
            r1_fv     <= i_smp.v_coord[COORD_W-1] ? '0 : i_smp.v_coord[FRAC_W-1:0];
        end
    end

    always_comb begin
        logic in_range;
        in_range = (int'(r1_x) < MAX_WIDTH) && (int'(r1_y) < MAX_HEIGHT);
        n2_word  = r_pal_q;
        n2_waddr = addr_of(XW'(r1_x), YW'(r1_y));
        n2_kind  = K_NONE;
        if (r1_action == ACT_IDX_WR) begin
            n2_kind = in_range ? K_WRITE : K_NONE;
        end else if (r1_action == ACT_ARGB_WR) begin
            n2_kind = in_range ? K_WRITE : K_NONE;
            n2_word = {r1_word[31:24], r1_word[7:0], r1_word[15:8], r1_word[23:16]};
        end else if (r1_action == ACT_POINT) begin
            n2_kind = K_POINT;
        end else if (r1_action == ACT_BILIN) begin
            n2_kind = K_BILIN;
        end
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (s2_ld) begin
                r2_v <= r1_v;
            end
            if (r2_v && s2_step) begin
                r_cnt <= s2_last ? 2'd0 : r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r2_kind  <= n2_kind;
            r2_word  <= n2_word;
            r2_waddr <= n2_waddr;
            r2_pu    <= PUW'(sx) * PUW'(r1_fu);
            r2_pv    <= PVW'(sy) * PVW'(r1_fv);
        end
    end

    // texel positions; the bilinear product never exceeds size-1 in texels
    always_comb begin
        logic [PUW:0]    ru;
        logic [PVW:0]    rv;
        logic [XW:0]     pxr;
        logic [YW:0]     pyr;
        logic [XW-1:0]   px;
        logic [YW-1:0]   py;
        logic [XW-1:0]   bx;
        logic [YW-1:0]   by;
        ru  = (PUW+1)'(r2_pu) + (PUW+1)'(17'h08000);
        rv  = (PVW+1)'(r2_pv) + (PVW+1)'(17'h08000);
        pxr = ru[PUW:FRAC_W];
        pyr = rv[PVW:FRAC_W];
        px  = (pxr > {1'b0, sx}) ? sx : pxr[XW-1:0];
        py  = (pyr > {1'b0, sy}) ? sy : pyr[YW-1:0];
        bx  = r2_pu[PUW-1:FRAC_W];
        by  = r2_pv[PVW-1:FRAC_W];
        if (r2_kind == K_POINT) begin
            x0 = px;
            x1 = px;
            y0 = py;
            y1 = py;
        end else begin
            x0 = bx;
            x1 = (bx == sx) ? bx : bx + 1'b1;
            y0 = by;
            y1 = (by == sy) ? by : by + 1'b1;
        end
        rd_addr = addr_of(r_cnt[0] ? x1 : x0, r_cnt[1] ? y1 : y0);
    end

    always_comb begin
        s2_step = 1'b1;
        s2_last = 1'b1;
        tex_we  = 1'b0;
        tex_re  = 1'b0;
        unique case (r2_kind)
            K_NONE: begin
            end
            K_WRITE: begin
                tex_we = r2_v;
            end
            K_POINT: begin
                s2_step = r_free;
                tex_re  = r2_v && r_free;
            end
            K_BILIN: begin
                s2_step = r_free;
                s2_last = (r_cnt == 2'd3);
                tex_re  = r2_v && r_free;
            end
        endcase
    end

    assign tex_addr = (r2_kind == K_WRITE) ? r2_waddr : rd_addr;

    // ---------------- texel RAM ----------------
    always_ff @(posedge i_clk) begin
        if (tex_we) begin
            r_tex_mem[tex_addr] <= r2_word;
        end
        if (tex_re) begin
            r_tex_q <= r_tex_mem[tex_addr];
        end
    end

    // ---------------- read return and gather ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
            r_g_v <= 1'b0;
        end else begin
            if (tex_re) begin
                r_r_v <= 1'b1;
            end else if (r_go) begin
                r_r_v <= 1'b0;
            end
            if (r_go && r_r_last) begin
                r_g_v <= 1'b1;
            end else if (g_go) begin
                r_g_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tex_re) begin
            r_r_slot <= r_cnt;
            r_r_last <= s2_last;
            r_r_all  <= (r2_kind == K_POINT);
            r_r_a    <= (r2_kind == K_POINT) ? '0 : r2_pu[FRAC_W-1 -: CH_W];
            r_r_b    <= (r2_kind == K_POINT) ? '0 : r2_pv[FRAC_W-1 -: CH_W];
        end
        if (r_go) begin
            // a point sample fills every slot so the blend passes it through
            for (int k = 0; k < 4; k++) begin
                if (r_r_all || r_r_slot == 2'(k)) begin
                    r_g_quad.texel[k] <= r_tex_q;
                end
            end
            if (r_r_last) begin
                r_g_quad.wa <= r_r_a;
                r_g_quad.wb <= r_r_b;
            end
        end
    end

    tsb_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_g_v),
        .i_quad  (r_g_quad),
        .o_ready (blend_ready),
        .o_res   (o_res)
    );

endmodule
